// ----- hw/rtl/sia_pkg.sv -----
`timescale 1ns / 1ps

package sia_pkg;

	// Countdown width and the widths fixed by the item fields
	localparam int unsigned DelayWidth     = 24;
	localparam int unsigned StepWidth      = 16;
	localparam int unsigned DelayTimeWidth = 24;
	localparam int unsigned CmpWidth       = (DelayWidth > StepWidth) ? DelayWidth : StepWidth;
	localparam int unsigned CfgIdxWidth    = 2;
	localparam int unsigned CfgDataWidth   = DelayTimeWidth;

	// Output command codes
	typedef enum logic [1:0] {
		CMD_ON     = 2'd0,
		CMD_OFF    = 2'd1,
		CMD_TOGGLE = 2'd2
	} cmd_t;

	// Switch type codes; code 7 is unused and issues nothing
	typedef logic [2:0] sw_type_t;
	localparam sw_type_t TYPE_NONE    = 3'd0;
	localparam sw_type_t TYPE_PRESS   = 3'd1;
	localparam sw_type_t TYPE_RELEASE = 3'd2;
	localparam sw_type_t TYPE_REMOTE  = 3'd3;
	localparam sw_type_t TYPE_PUSH    = 3'd4;
	localparam sw_type_t TYPE_DUAL    = 3'd5;
	localparam sw_type_t TYPE_DELAY   = 3'd6;

	// Request kinds
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_HIT  = 1'b1;

	// Configuration register indexes
	typedef logic [CfgIdxWidth-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_SWITCH_TYPE = 2'd0;
	localparam cfg_idx_t REG_PIN_PRESENT = 2'd1;
	localparam cfg_idx_t REG_DELAY_TIME  = 2'd2;

	typedef struct packed {
		sw_type_t                  switch_type;
		logic                      pin_present;
		logic [DelayTimeWidth-1:0] delay_time;
	} cfg_t;

	// Commands produced by one item, in order
	typedef struct packed {
		logic [1:0] cnt;
		cmd_t       cmd0;
		cmd_t       cmd1;
	} res_t;

endpackage

// ----- hw/rtl/sia_if.sv -----
`timescale 1ns / 1ps

interface sia_req_if import sia_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 req_type;
	logic [StepWidth-1:0] time_step;
	logic                 first_pin_level;
	logic                 second_pin_level;

	modport source (output valid, req_type, time_step, first_pin_level, second_pin_level,
		input ready);
	modport sink (input valid, req_type, time_step, first_pin_level, second_pin_level,
		output ready);
endinterface

interface sia_rsp_if import sia_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic       last_command;

	modport source (output valid, command, last_command, input ready);
	modport sink (input valid, command, last_command, output ready);
endinterface

interface sia_cfg_if import sia_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CfgIdxWidth-1:0]  index;
	logic [CfgDataWidth-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/sia_cfg_regs.sv -----
`timescale 1ns / 1ps

module sia_cfg_regs import sia_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	sia_cfg_if.sink    cfg,
	output cfg_t       cfg_q
);

	// Always take a write
	assign cfg.ready = 1'b1;

	// Update the addressed register on a transfer; other indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.switch_type <= TYPE_NONE;
			cfg_q.pin_present <= 1'b1;
			cfg_q.delay_time  <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SWITCH_TYPE: cfg_q.switch_type <= cfg.data[2:0];
				REG_PIN_PRESENT: cfg_q.pin_present <= cfg.data[0];
				REG_DELAY_TIME:  cfg_q.delay_time  <= cfg.data[DelayTimeWidth-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- hw/rtl/sia_eval.sv -----
`timescale 1ns / 1ps

module sia_eval import sia_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	sia_req_if.sink req,
	input  cfg_t    cfg_q,
	input  logic    load_ok,
	output logic    load,
	output res_t    res
);

	logic                 valid_s1;
	logic                 req_type_s1;
	logic [StepWidth-1:0] time_step_s1;
	logic                 p1_level_s1;
	logic                 p2_level_s1;

	logic                  first_latch_q;
	logic                  second_latch_q;
	logic [DelayWidth-1:0] delay_rem_q;

	logic                  first_latch_d;
	logic                  second_latch_d;
	logic [DelayWidth-1:0] delay_rem_d;
	logic [DelayWidth-1:0] delay_load;
	logic [CmpWidth-1:0]   rem_ext;
	logic [CmpWidth-1:0]   step_ext;
	logic [CmpWidth-1:0]   rem_diff;
	logic [2:0]            ev;
	cmd_t                  c0, c1, c2;

	// Evaluate the held item whenever the result buffer can take its commands
	assign load      = valid_s1 && load_ok;
	assign req.ready = !valid_s1 || load_ok;

	// Hold the input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1  <= req.req_type;
			time_step_s1 <= req.time_step;
			p1_level_s1  <= req.first_pin_level;
			p2_level_s1  <= req.second_pin_level;
		end
	end

	// Countdown arithmetic
	assign delay_load = DelayWidth'(cfg_q.delay_time);
	assign rem_ext    = CmpWidth'(delay_rem_q);
	assign step_ext   = CmpWidth'(time_step_s1);
	assign rem_diff   = rem_ext - step_ext;

	// Work out the events of this item in issue order: countdown or hit, first pin, second pin
	always_comb begin
		ev             = 3'b000;
		c0             = CMD_OFF;
		c1             = CMD_OFF;
		c2             = CMD_OFF;
		first_latch_d  = first_latch_q;
		second_latch_d = second_latch_q;
		delay_rem_d    = delay_rem_q;
		if (req_type_s1 == REQ_HIT) begin
			case (cfg_q.switch_type)
				TYPE_NONE, TYPE_PRESS, TYPE_RELEASE, TYPE_REMOTE: begin
					ev[0] = 1'b1;
					c0    = CMD_TOGGLE;
				end
				TYPE_PUSH: begin
					ev[0] = 1'b1;
					c0    = CMD_ON;
					ev[1] = 1'b1;
					c1    = CMD_OFF;
				end
				TYPE_DUAL: begin
					ev[0] = 1'b1;
					c0    = CMD_ON;
				end
				TYPE_DELAY: begin
					ev[0]       = 1'b1;
					c0          = CMD_ON;
					delay_rem_d = delay_load;
				end
				default: ;
			endcase
		end else begin
			// Run the countdown first
			if (cfg_q.switch_type == TYPE_DELAY && delay_rem_q != '0) begin
				if (step_ext >= rem_ext) begin
					delay_rem_d = '0;
					ev[0]       = 1'b1;
					c0          = CMD_OFF;
				end else begin
					delay_rem_d = DelayWidth'(rem_diff);
				end
			end
			if (cfg_q.pin_present) begin
				if (cfg_q.switch_type == TYPE_DUAL) begin
					if (!p1_level_s1) begin
						if (!first_latch_q) begin
							first_latch_d = 1'b1;
							ev[1]         = 1'b1;
							c1            = CMD_ON;
						end
					end else begin
						first_latch_d = 1'b0;
					end
					if (!p2_level_s1) begin
						if (!second_latch_q) begin
							second_latch_d = 1'b1;
							ev[2]          = 1'b1;
							c2             = CMD_OFF;
						end
					end else begin
						second_latch_d = 1'b0;
					end
				end else if (!p1_level_s1) begin
					if (!first_latch_q) begin
						first_latch_d = 1'b1;
						case (cfg_q.switch_type)
							TYPE_PRESS, TYPE_REMOTE: begin
								ev[1] = 1'b1;
								c1    = CMD_TOGGLE;
							end
							TYPE_PUSH: begin
								ev[1] = 1'b1;
								c1    = CMD_ON;
							end
							TYPE_DELAY: begin
								ev[1]       = 1'b1;
								c1          = CMD_ON;
								delay_rem_d = delay_load;
							end
							default: ;
						endcase
					end
				end else if (first_latch_q) begin
					first_latch_d = 1'b0;
					case (cfg_q.switch_type)
						TYPE_RELEASE: begin
							ev[1] = 1'b1;
							c1    = CMD_TOGGLE;
						end
						TYPE_PUSH: begin
							ev[1] = 1'b1;
							c1    = CMD_OFF;
						end
						default: ;
					endcase
				end
			end
		end
	end

	// Pack the events into at most two ordered commands
	always_comb begin
		res.cmd0 = c2;
		res.cmd1 = c2;
		if (ev[0]) begin
			res.cmd0 = c0;
			res.cmd1 = ev[1] ? c1 : c2;
		end else if (ev[1]) begin
			res.cmd0 = c1;
		end
		case (ev)
			3'b000:                 res.cnt = 2'd0;
			3'b001, 3'b010, 3'b100: res.cnt = 2'd1;
			default:                res.cnt = 2'd2;
		endcase
	end

	// Commit the switch state when the item is evaluated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_latch_q  <= 1'b0;
			second_latch_q <= 1'b0;
			delay_rem_q    <= '0;
		end else if (load) begin
			first_latch_q  <= first_latch_d;
			second_latch_q <= second_latch_d;
			delay_rem_q    <= delay_rem_d;
		end
	end

endmodule

// ----- hw/rtl/sia_out_buf.sv -----
`timescale 1ns / 1ps

module sia_out_buf import sia_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  res_t      res,
	output logic      load_ok,
	sia_rsp_if.source rsp
);

	logic [1:0] cnt_q;
	cmd_t       cmd0_q;
	cmd_t       cmd1_q;
	logic       xfer;

	assign xfer    = rsp.valid && rsp.ready;
	// Take new commands when empty or when the last one leaves this cycle
	assign load_ok = (cnt_q == 2'd0) || (cnt_q == 2'd1 && xfer);

	assign rsp.valid        = cnt_q != 2'd0;
	assign rsp.command      = cmd0_q;
	assign rsp.last_command = cnt_q == 2'd1;

	// Track how many commands wait
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res.cnt;
		end else if (xfer) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Load or advance the command slots
	always_ff @(posedge clk) begin
		if (load) begin
			cmd0_q <= res.cmd0;
			cmd1_q <= res.cmd1;
		end else if (xfer) begin
			cmd0_q <= cmd1_q;
		end
	end

endmodule

// ----- hw/rtl/switch_input_action_controller_core.sv -----
`timescale 1ns / 1ps

// Switch input action controller. Each request is a timer tick (elapsed time and the two
// active-low pin levels) or a hit event; it yields zero, one or two commands (ON, OFF,
// TOGGLE) on the response channel, the final one flagged by last_command. A request sits
// in an input register and is evaluated combinationally into a two-slot command buffer,
// which the single response channel drains one command per transfer. A new request
// can be taken into the input register while the previous commands are still being
// handed out. Write the configuration registers (switch_type, pin_present, delay_time)
// only while idle.
module switch_input_action_controller_core import sia_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sia_cfg_if.sink   cfg,
	sia_req_if.sink   req,
	sia_rsp_if.source rsp
);

	cfg_t cfg_q;
	res_t res;
	logic load;
	logic load_ok;

	sia_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	sia_eval u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.cfg_q   (cfg_q),
		.load_ok (load_ok),
		.load    (load),
		.res     (res)
	);

	sia_out_buf u_out_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.res     (res),
		.load_ok (load_ok),
		.rsp     (rsp)
	);

`ifndef NO_ASSERTIONS
	// Only defined command codes leave the block
	a_cmd_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.command == CMD_ON || rsp.command == CMD_OFF ||
			rsp.command == CMD_TOGGLE))
		else $error("undefined command code");

	// A non-final command is always followed by the final one of its request
	a_pair_follow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready && !rsp.last_command |=> rsp.valid && rsp.last_command)
		else $error("second command of a pair missing");

	// With nothing pending on the response side a request is always taken
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp.valid |-> req.ready)
		else $error("request stalled with empty response buffer");
`endif

endmodule
